@@ rtl/lsba_pkg.sv @@
// Shared types and fixed constants for the log-spaced band averager.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lsba_pkg;

   // Fixed field widths of the word interface.
   localparam int MagW = 16;
   localparam int IdxW = 6;
   localparam logic [MagW-1:0] FullScale = {MagW{1'b1}};

   // The band-close divider retires one quotient bit per cycle.
   localparam int DivSteps = MagW;
   localparam int StepW    = $clog2(DivSteps);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // an input word is taken this cycle
      logic div_load;  // the word closes a band: start the divider
      logic div_step;  // retire one quotient bit
      logic out_load;  // move the quotient into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic close_hit; // the word now offered would close a band
   } status_type;

endpackage

`default_nettype wire

@@ rtl/lsba_ctrl.sv @@
// Controller of the band averager: divider sequencer, input stall and output valid.
// Depends on lsba_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module lsba_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  lsba_pkg::status_type status,
   output lsba_pkg::cmd_type    cmd
);
   import lsba_pkg::*;

   div_state_type    state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             busy;

   // Command and handshake outputs.
   always_comb begin
      busy = 1'b1;
      unique case (state_ff)
         DIV_IDLE: busy = 1'b0;
         DIV_RUN:  busy = 1'b1;
         DIV_DONE: busy = 1'b1;
         default:  busy = 1'b1;
      endcase
      // Only a band-closing word needs the divider, so only such a word waits.
      req_stall      = status.close_hit && busy;
      cmd.accept     = req_valid && !req_stall;
      cmd.div_load   = cmd.accept && status.close_hit;
      cmd.div_step   = (state_ff == DIV_RUN);
      cmd.out_load   = (state_ff == DIV_DONE) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid      = rsp_valid_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            step_in = '0;
            if (cmd.div_load) begin
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(DivSteps - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            step_in = '0;
            if (cmd.out_load) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
            step_in  = '0;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DIV_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lsba_dp.sv @@
// Datapath of the band averager: frame counters, band accumulator, band edge
// table, restoring divider and output register. Depends on lsba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsba_dp #(
   parameter int BINS = 512,
   parameter int BARS = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  lsba_pkg::cmd_type           cmd,
   output lsba_pkg::status_type        status,
   input  wire [lsba_pkg::MagW-1:0]    req_magnitude,
   input  wire                         req_frame_start,
   output logic [lsba_pkg::IdxW-1:0]   rsp_bar_index,
   output logic [lsba_pkg::MagW-1:0]   rsp_bar_height,
   output logic [lsba_pkg::MagW-1:0]   rsp_red_level,
   output logic [lsba_pkg::MagW-1:0]   rsp_green_level,
   output logic                        rsp_last_bar
);
   import lsba_pkg::*;

   localparam int  PosW     = $clog2(BINS);
   localparam int  EndW     = $clog2(BINS + 1);
   localparam int  FillW    = $clog2(BINS);
   localparam int  SumW     = MagW + FillW;
   localparam int  BandW    = $clog2(BARS + 1);
   localparam int  TabW     = $clog2(BARS);
   localparam int  TabDepth = 1 << TabW;
   localparam int  MaxLimbs = (BARS * 13) / 32 + 2;
   localparam real LnStep   = $ln(real'(BINS)) / real'(BARS);

   // Exact test of s^BARS <= BINS^i with multi-word integers.
   function automatic bit pow_le_exact(int unsigned s, int unsigned i);
      logic [31:0]     a [MaxLimbs];
      logic [31:0]     b [MaxLimbs];
      longint unsigned carry;
      longint unsigned v;
      bit              le;
      bit              decided;
      for (int k = 0; k < MaxLimbs; k++) begin
         a[k] = '0;
         b[k] = '0;
      end
      a[0] = 32'd1;
      b[0] = 32'd1;
      for (int r = 0; r < BARS; r++) begin
         carry = 0;
         for (int k = 0; k < MaxLimbs; k++) begin
            v     = longint'(a[k]) * longint'(s) + carry;
            a[k]  = v[31:0];
            carry = v >> 32;
         end
      end
      for (int r = 0; r < int'(i); r++) begin
         carry = 0;
         for (int k = 0; k < MaxLimbs; k++) begin
            v     = longint'(b[k]) * longint'(BINS) + carry;
            b[k]  = v[31:0];
            carry = v >> 32;
         end
      end
      le      = 1'b1;
      decided = 1'b0;
      for (int k = MaxLimbs - 1; k >= 0; k--) begin
         if (!decided && a[k] != b[k]) begin
            le      = (a[k] < b[k]);
            decided = 1'b1;
         end
      end
      return le;
   endfunction

   // Logarithms settle the comparison unless the two sides nearly meet.
   function automatic bit pow_le(int unsigned s, int unsigned i);
      real d;
      d = real'(BARS) * $ln(real'(s)) - real'(i) * $ln(real'(BINS));
      if (d < -1.0e-6) begin
         return 1'b1;
      end else if (d > 1.0e-6) begin
         return 1'b0;
      end
      return pow_le_exact(s, i);
   endfunction

   // Largest s in 1 .. BINS with s^BARS <= BINS^i.
   function automatic int unsigned int_root(int unsigned i);
      real         est;
      int unsigned c;
      est = $exp(LnStep * real'(i));
      c   = int'($rtoi($floor(est)));
      if (c < 1) begin
         c = 1;
      end
      if (c > BINS) begin
         c = BINS;
      end
      for (int k = 0; k < 4; k++) begin
         if (c < BINS && pow_le(c + 1, i)) begin
            c = c + 1;
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (c > 1 && !pow_le(c, i)) begin
            c = c - 1;
         end
      end
      return c;
   endfunction

   // Exclusive end bin of every band, packed; unused slots hold BINS.
   function automatic logic [TabDepth*EndW-1:0] build_band_ends();
      logic [TabDepth*EndW-1:0] flat;
      int unsigned              f_cur;
      int unsigned              f_next;
      int unsigned              last_end;
      int unsigned              start;
      int unsigned              stop;
      flat     = '0;
      last_end = 0;
      f_cur    = int_root(0);
      for (int i = 0; i < TabDepth; i++) begin
         if (i < BARS) begin
            f_next = int_root(i + 1);
            start  = (f_cur < last_end) ? last_end : f_cur;
            stop   = f_next;
            if (stop <= start) begin
               stop = start + 1;
            end
            if (stop > BINS) begin
               stop = BINS;
            end
            flat[i*EndW +: EndW] = EndW'(stop);
            last_end = stop;
            f_cur    = f_next;
         end else begin
            flat[i*EndW +: EndW] = EndW'(BINS);
         end
      end
      return flat;
   endfunction

   localparam logic [TabDepth*EndW-1:0] BandEnds = build_band_ends();

   logic [PosW-1:0]  bin_position_ff, bin_position_in;
   logic [BandW-1:0] band_number_ff, band_number_in;
   logic [SumW-1:0]  band_sum_ff, band_sum_in;
   logic [FillW-1:0] band_fill_ff, band_fill_in;

   logic [FillW-1:0] div_rem_ff, div_rem_in;
   logic [MagW-1:0]  div_num_ff, div_num_in;
   logic [FillW-1:0] div_den_ff, div_den_in;
   logic [IdxW-1:0]  div_index_ff, div_index_in;
   logic             div_last_ff, div_last_in;

   logic [IdxW-1:0]  out_index_ff, out_index_in;
   logic [MagW-1:0]  out_height_ff, out_height_in;
   logic             out_last_ff, out_last_in;

   logic [PosW-1:0]  pos_eff;
   logic [BandW-1:0] band_eff;
   logic [SumW-1:0]  sum_eff, sum_acc;
   logic [FillW-1:0] fill_eff, fill_acc;
   logic [EndW-1:0]  pos_next, band_end;
   logic             in_band, close_hit;
   logic [FillW:0]   trial, diff;
   logic             trial_ge;

   // Frame counters and band accumulator.
   always_comb begin
      pos_eff  = req_frame_start ? '0 : bin_position_ff;
      band_eff = req_frame_start ? '0 : band_number_ff;
      sum_eff  = req_frame_start ? '0 : band_sum_ff;
      fill_eff = req_frame_start ? '0 : band_fill_ff;

      in_band   = (pos_eff != '0) && (band_eff < BandW'(BARS));
      band_end  = BandEnds[band_eff[TabW-1:0]*EndW +: EndW];
      pos_next  = EndW'(pos_eff) + EndW'(1);
      close_hit = in_band && (pos_next >= band_end);
      sum_acc   = sum_eff + {{FillW{1'b0}}, req_magnitude};
      fill_acc  = fill_eff + FillW'(1);

      status.close_hit = close_hit;

      bin_position_in = bin_position_ff;
      band_number_in  = band_number_ff;
      band_sum_in     = band_sum_ff;
      band_fill_in    = band_fill_ff;
      if (cmd.accept) begin
         bin_position_in = PosW'(pos_next);
         band_number_in  = band_eff;
         band_sum_in     = sum_eff;
         band_fill_in    = fill_eff;
         if (in_band) begin
            if (close_hit) begin
               band_number_in = band_eff + BandW'(1);
               band_sum_in    = '0;
               band_fill_in   = '0;
            end else begin
               band_sum_in  = sum_acc;
               band_fill_in = fill_acc;
            end
         end
         if (pos_next >= EndW'(BINS)) begin
            bin_position_in = '0;
            band_number_in  = '0;
            band_sum_in     = '0;
            band_fill_in    = '0;
         end
      end
   end

   // Restoring divider. The mean is below 2^MagW, so the high part of the
   // sum is already below the divisor and MagW steps give the whole quotient.
   always_comb begin
      trial    = {div_rem_ff, div_num_ff[MagW-1]};
      diff     = trial - {1'b0, div_den_ff};
      trial_ge = (trial >= {1'b0, div_den_ff});

      div_rem_in   = div_rem_ff;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;
      div_index_in = div_index_ff;
      div_last_in  = div_last_ff;
      if (cmd.div_load) begin
         div_rem_in   = sum_acc[SumW-1:MagW];
         div_num_in   = sum_acc[MagW-1:0];
         div_den_in   = fill_acc;
         div_index_in = IdxW'(band_eff);
         div_last_in  = (band_eff == BandW'(BARS - 1));
      end else if (cmd.div_step) begin
         div_rem_in = trial_ge ? diff[FillW-1:0] : trial[FillW-1:0];
         div_num_in = {div_num_ff[MagW-2:0], trial_ge};
      end

      out_index_in  = out_index_ff;
      out_height_in = out_height_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_load) begin
         out_index_in  = div_index_ff;
         out_height_in = div_num_ff;
         out_last_in   = div_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_position_ff <= '0;
         band_number_ff  <= '0;
         band_sum_ff     <= '0;
         band_fill_ff    <= '0;
      end else begin
         bin_position_ff <= bin_position_in;
         band_number_ff  <= band_number_in;
         band_sum_ff     <= band_sum_in;
         band_fill_ff    <= band_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff    <= div_rem_in;
      div_num_ff    <= div_num_in;
      div_den_ff    <= div_den_in;
      div_index_ff  <= div_index_in;
      div_last_ff   <= div_last_in;
      out_index_ff  <= out_index_in;
      out_height_ff <= out_height_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_bar_index   = out_index_ff;
   assign rsp_bar_height  = out_height_ff;
   assign rsp_red_level   = out_height_ff;
   assign rsp_green_level = FullScale - out_height_ff;
   assign rsp_last_bar    = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/log_spaced_band_averager.sv @@
// A result word is worked out by the divider once the word that closes its band is taken,
// then leaves through the output register. One bin word is taken per cycle; a band-closing
// word waits while the divider is busy, and longer while a stalled result word still holds the output register.
// Reset (synchronous, active high) clears the frame counters, the divider
// sequencer and the output valid; the band edge table is constant logic.
// Top level; depends on lsba_pkg, lsba_ctrl and lsba_dp.
`timescale 1ns / 1ps
`default_nettype none

module log_spaced_band_averager #(
   parameter int BINS = 512,
   parameter int BARS = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [lsba_pkg::MagW-1:0]    req_magnitude,
   input  wire                         req_frame_start,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [lsba_pkg::IdxW-1:0]   rsp_bar_index,
   output logic [lsba_pkg::MagW-1:0]   rsp_bar_height,
   output logic [lsba_pkg::MagW-1:0]   rsp_red_level,
   output logic [lsba_pkg::MagW-1:0]   rsp_green_level,
   output logic                        rsp_last_bar
);
   import lsba_pkg::*;

   // The block splits into a controller and a datapath. The datapath counts
   // the bin position of each word, keeps the number, sum and fill of the
   // band being gathered, and compares the position with the band's end bin
   // from a table built at elaboration. Bin zero of each frame is skipped,
   // and a frame start word restarts all counting.
   //
   // When a word closes a band, its sum and fill go to a restoring divider
   // that retires one quotient bit per cycle. The controller sequences it
   // and moves the finished mean into an output register, so new bin words
   // keep flowing while a result waits downstream. Only another band-closing
   // word has to wait for the divider to become free.

   cmd_type    cmd;
   status_type status;

   lsba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lsba_dp #(
      .BINS (BINS),
      .BARS (BARS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_magnitude   (req_magnitude),
      .req_frame_start (req_frame_start),
      .rsp_bar_index   (rsp_bar_index),
      .rsp_bar_height  (rsp_bar_height),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_last_bar    (rsp_last_bar)
   );

endmodule

`default_nettype wire

@@ rtl/lsba_checker.sv @@
// Port-level checks of the band averager and the bind that attaches them.
// Depends on lsba_pkg and on the top level log_spaced_band_averager.
`timescale 1ns / 1ps
`default_nettype none

module lsba_checker #(
   parameter int BARS = 64
) (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_stall,
   input wire                       rsp_valid,
   input wire                       rsp_stall,
   input wire [lsba_pkg::IdxW-1:0]  rsp_bar_index,
   input wire [lsba_pkg::MagW-1:0]  rsp_bar_height,
   input wire [lsba_pkg::MagW-1:0]  rsp_red_level,
   input wire [lsba_pkg::MagW-1:0]  rsp_green_level,
   input wire                       rsp_last_bar
);
   import lsba_pkg::*;

   // A stalled result word holds its valid and its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bar_height)
         && $stable(rsp_bar_index) && $stable(rsp_last_bar))
      else $error("stalled result word changed");

   // The two colors follow the height.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_level == rsp_bar_height
         && rsp_green_level == FullScale - rsp_bar_height)
      else $error("color levels do not match the height");

   // The final band carries the last index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bar |-> rsp_bar_index == IdxW'(BARS - 1))
      else $error("last band flag on a wrong index");

   // No result word is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The divider is free after reset, so the input is not stalled then.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_stall)
      else $error("input stalled straight out of reset");

endmodule

bind log_spaced_band_averager lsba_checker #(
   .BARS (BARS)
) u_lsba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_bar_index   (rsp_bar_index),
   .rsp_bar_height  (rsp_bar_height),
   .rsp_red_level   (rsp_red_level),
   .rsp_green_level (rsp_green_level),
   .rsp_last_bar    (rsp_last_bar)
);

`default_nettype wire
